/* hw/rtl/mia_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the adjugate matrix inverter.
// Used by the interfaces, the controller, the datapath and the top level.
package mia_pkg;

	localparam int CFG_W  = 3;
	localparam int ELEM_W = 32;
	localparam int DET_W  = 48;
	localparam int ACC_W  = 64;
	localparam int DIV_STEPS = 80;

	localparam logic [CFG_W-1:0] SIZE_RESET = 3'd4;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ONE_Q16 = 64'sd65536;

	// Quotient cap of the restoring division and the output saturation bounds.
	localparam logic [33:0] Q_CAP = 34'h2_0000_0000;
	localparam logic [34:0] Q_NEG_LIM = 35'h0_8000_0000;
	localparam logic [34:0] Q_POS_LIM = 35'h0_7FFF_FFFF;

	// Datapath operations issued by the controller.
	typedef logic [3:0] op_t;
	localparam op_t OP_NONE  = 4'd0;
	localparam op_t OP_LOAD  = 4'd1;
	localparam op_t OP_OPL   = 4'd2;
	localparam op_t OP_MAG   = 4'd3;
	localparam op_t OP_P1    = 4'd4;
	localparam op_t OP_P2    = 4'd5;
	localparam op_t OP_COMB  = 4'd6;
	localparam op_t OP_ACC   = 4'd7;
	localparam op_t OP_CLR   = 4'd8;
	localparam op_t OP_WT    = 4'd9;
	localparam op_t OP_DET   = 4'd10;
	localparam op_t OP_DINIT = 4'd11;
	localparam op_t OP_DSTEP = 4'd12;
	localparam op_t OP_DEND  = 4'd13;
	localparam op_t OP_ZERO  = 4'd14;

	typedef struct packed {
		op_t  op;
		logic src_one;
		logic opneg;
		logic termneg;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic sing;
	} status_t;

	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_neg(input logic signed [ACC_W-1:0] a);
		return (a == ACC_MIN) ? ACC_MAX : -a;
	endfunction

	function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] a);
		return a[ACC_W-1] ? (ACC_W'(0) - ACC_W'(a)) : ACC_W'(a);
	endfunction

	function automatic logic signed [ACC_W-1:0] signed_sat(input logic [ACC_W-1:0] m,
			input logic neg);
		if (neg) begin
			return m[ACC_W-1] ? ACC_MIN : -$signed(m);
		end
		return m[ACC_W-1] ? ACC_MAX : $signed(m);
	endfunction

endpackage

/* hw/rtl/mia_intf.sv */
`timescale 1ns / 1ps
// Handshake interfaces of the matrix inverter: configuration, element input, result output.
// Depends on mia_pkg for the field widths.
interface mia_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mia_pkg::CFG_W-1:0]  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mia_elem_if;
	logic                              valid;
	logic                              ready;
	logic signed [mia_pkg::ELEM_W-1:0] element;
	modport source(output valid, output element, input ready);
	modport sink(input valid, input element, output ready);
endinterface

interface mia_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [mia_pkg::ELEM_W-1:0] inverse_element;
	logic signed [mia_pkg::DET_W-1:0]  determinant;
	logic                              singular;
	logic                              last;
	modport source(output valid, output inverse_element, output determinant,
		output singular, output last, input ready);
	modport sink(input valid, input inverse_element, input determinant,
		input singular, input last, output ready);
endinterface

/* hw/rtl/matrix_inverse_adjugate_core.sv */
`timescale 1ns / 1ps
// Top level of the adjugate matrix inverter: controller plus datapath.
// Depends on mia_pkg, mia_intf, mia_controller and mia_datapath.
//
// Usage. Write the order n (1 to MAX_N) on cfg; a write restarts the load. cfg.ready is
// high only while the block is loading and no word is offered on matrix. Then send
// n*n signed Q16.16 words on matrix in row-major order, one per cycle while ready is
// high. After the last word the block builds every minor from the smallest up with one
// shared 32x32 multiplier, expands the determinant along the first row, and divides
// each cofactor by the determinant in a restoring divider that retires one quotient
// bit per cycle (80 steps a word). Results leave on inverse in row-major order, each
// with the saturated Q32.16 determinant, the singular flag and last on the final word.
// For order four the time from the last input word to the last result word is dominated
// by the divider and the minor sweep over all row and column masks.
// matrix.ready is low from the last input word until the last result is taken. When the
// receiver stalls, the current result word holds and the sequencer waits.
// Reset returns to loading with order four and a load count of zero.
module matrix_inverse_adjugate_core #(
	parameter int MAX_N = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	mia_cfg_if.sink           cfg,
	mia_elem_if.sink          matrix,
	mia_res_if.source         inverse
);
	localparam int CELLS = MAX_N * MAX_N;
	localparam int EAW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int TAW = 2 * MAX_N;

	mia_pkg::cmd_t    cmd;
	mia_pkg::status_t status;
	logic [EAW-1:0]   e_waddr;
	logic [EAW-1:0]   e_raddr;
	logic [TAW-1:0]   t_addr;

	mia_controller #(.MAX_N(MAX_N)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg.valid),
		.cfg_data (cfg.data),
		.cfg_ready(cfg.ready),
		.in_valid (matrix.valid),
		.in_ready (matrix.ready),
		.out_valid(inverse.valid),
		.out_ready(inverse.ready),
		.status   (status),
		.cmd      (cmd),
		.e_waddr  (e_waddr),
		.e_raddr  (e_raddr),
		.t_addr   (t_addr)
	);

	mia_datapath #(.MAX_N(MAX_N)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.e_waddr        (e_waddr),
		.e_raddr        (e_raddr),
		.t_addr         (t_addr),
		.element        (matrix.element),
		.status         (status),
		.inverse_element(inverse.inverse_element),
		.determinant    (inverse.determinant),
		.singular       (inverse.singular),
		.last           (inverse.last)
	);
endmodule

/* hw/rtl/mia_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hw/rtl/mia_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the matrix inverter: element and minor RAMs, shared multiply unit,
// accumulator, determinant register, bit-serial divider and result register.
// Depends on mia_pkg and mia_ram.
module mia_datapath #(
	parameter int MAX_N = 4,
	localparam int CELLS = MAX_N * MAX_N,
	localparam int EAW = (CELLS > 1) ? $clog2(CELLS) : 1,
	localparam int TAW = 2 * MAX_N
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mia_pkg::cmd_t                      cmd,
	input  logic [EAW-1:0]                     e_waddr,
	input  logic [EAW-1:0]                     e_raddr,
	input  logic [TAW-1:0]                     t_addr,
	input  logic signed [mia_pkg::ELEM_W-1:0]  element,
	output mia_pkg::status_t                   status,
	output logic signed [mia_pkg::ELEM_W-1:0]  inverse_element,
	output logic signed [mia_pkg::DET_W-1:0]   determinant,
	output logic                               singular,
	output logic                               last
);
	localparam int W = mia_pkg::ACC_W;
	localparam int EW = mia_pkg::ELEM_W;
	localparam logic signed [W-1:0] DET_HI = W'((64'sd1 <<< (mia_pkg::DET_W - 1)) - 1);
	localparam logic signed [W-1:0] DET_LO = W'(-(64'sd1 <<< (mia_pkg::DET_W - 1)));

	logic [EW-1:0]       e_rd;
	logic [W-1:0]        t_rd;

	logic signed [W-1:0]  op_q;
	logic signed [EW-1:0] el_q;
	logic [EW-1:0]        ma_q;
	logic [W-1:0]         mb_q;
	logic                 neg_q;
	logic [W-1:0]         plo_q;
	logic [W-1:0]         phi_q;
	logic signed [W-1:0]  term_q;
	logic signed [W-1:0]  acc_q;
	logic signed [W-1:0]  det_q;
	logic [W+15:0]        x_q;
	logic [W-1:0]         d_q;
	logic [W-1:0]         rem_q;
	logic [33:0]          q_q;
	logic                 qneg_q;
	logic signed [EW-1:0] out_elem_q;
	logic                 out_last_q;

	logic [W:0]           r2;
	logic                 ge;
	logic [34:0]          q2;
	logic [34:0]          qf;
	logic [W-1:0]         m_prod;
	logic signed [W-1:0]  det_clamped;

	mia_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_elem_ram (
		.clk  (clk),
		.we   (cmd.op == mia_pkg::OP_LOAD),
		.waddr(e_waddr),
		.wdata(element),
		.raddr(e_raddr),
		.rdata(e_rd)
	);

	mia_ram #(.WIDTH(W), .DEPTH(1 << TAW)) u_minor_ram (
		.clk  (clk),
		.we   (cmd.op == mia_pkg::OP_WT),
		.waddr(t_addr),
		.wdata(acc_q),
		.raddr(t_addr),
		.rdata(t_rd)
	);

	always_comb begin
		r2 = {rem_q, x_q[W+15]};
		ge = r2 >= {1'b0, d_q};
		q2 = {q_q, ge};
		qf = {1'b0, q_q} + 35'((rem_q >= (d_q - rem_q)) ? 1 : 0);
		// A high partial product at or above 2^47 overflows the Q48.16 result.
		if (phi_q >= (W'(1) << 47)) begin
			m_prod = '1;
		end else begin
			m_prod = (phi_q << 16) + ((plo_q + W'(16'h8000)) >> 16);
		end
		if (det_q > DET_HI) begin
			det_clamped = DET_HI;
		end else if (det_q < DET_LO) begin
			det_clamped = DET_LO;
		end else begin
			det_clamped = det_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q <= '0;
		end else if (cmd.op == mia_pkg::OP_DET) begin
			det_q <= acc_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mia_pkg::OP_OPL: begin
				if (cmd.src_one) begin
					op_q <= mia_pkg::ONE_Q16;
				end else begin
					op_q <= cmd.opneg ? mia_pkg::sat_neg($signed(t_rd)) : $signed(t_rd);
				end
				el_q <= $signed(e_rd);
			end
			mia_pkg::OP_MAG: begin
				ma_q  <= el_q[EW-1] ? (EW'(0) - EW'(el_q)) : EW'(el_q);
				mb_q  <= mia_pkg::mag64(op_q);
				neg_q <= el_q[EW-1] ^ op_q[W-1];
			end
			mia_pkg::OP_P1: begin
				plo_q <= W'(mb_q[31:0]) * W'(ma_q);
			end
			mia_pkg::OP_P2: begin
				phi_q <= W'(mb_q[63:32]) * W'(ma_q);
			end
			mia_pkg::OP_COMB: begin
				term_q <= mia_pkg::signed_sat(m_prod, neg_q);
			end
			mia_pkg::OP_ACC: begin
				acc_q <= mia_pkg::sat_add(acc_q,
					cmd.termneg ? mia_pkg::sat_neg(term_q) : term_q);
			end
			mia_pkg::OP_CLR: begin
				acc_q <= '0;
			end
			mia_pkg::OP_DINIT: begin
				x_q    <= {mia_pkg::mag64(op_q), 16'b0};
				d_q    <= mia_pkg::mag64(det_q);
				rem_q  <= '0;
				q_q    <= '0;
				qneg_q <= op_q[W-1] ^ det_q[W-1];
			end
			mia_pkg::OP_DSTEP: begin
				rem_q <= ge ? W'(r2 - {1'b0, d_q}) : W'(r2);
				x_q   <= x_q << 1;
				q_q   <= (q2 > 35'(mia_pkg::Q_CAP)) ? mia_pkg::Q_CAP : q2[33:0];
			end
			mia_pkg::OP_DEND: begin
				if (qneg_q) begin
					out_elem_q <= (qf > mia_pkg::Q_NEG_LIM) ? $signed({1'b1, {(EW-1){1'b0}}})
						: $signed(EW'(35'd0 - qf));
				end else begin
					out_elem_q <= (qf > mia_pkg::Q_POS_LIM) ? $signed({1'b0, {(EW-1){1'b1}}})
						: $signed(qf[EW-1:0]);
				end
				out_last_q <= cmd.last;
			end
			mia_pkg::OP_ZERO: begin
				out_elem_q <= '0;
				out_last_q <= cmd.last;
			end
			default: begin
			end
		endcase
	end

	assign status.sing     = (det_q == '0);
	assign inverse_element = out_elem_q;
	assign determinant     = det_clamped[mia_pkg::DET_W-1:0];
	assign singular        = (det_q == '0);
	assign last            = out_last_q;
endmodule

/* hw/rtl/mia_controller.sv */
`timescale 1ns / 1ps
// Sequencer of the matrix inverter: load count, minor enumeration by row and column masks,
// determinant expansion, per-element division and the output handshake.
// Depends on mia_pkg.
module mia_controller #(
	parameter int MAX_N = 4,
	localparam int CELLS = MAX_N * MAX_N,
	localparam int EAW = (CELLS > 1) ? $clog2(CELLS) : 1,
	localparam int TAW = 2 * MAX_N
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [mia_pkg::CFG_W-1:0]   cfg_data,
	output logic                        cfg_ready,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  mia_pkg::status_t            status,
	output mia_pkg::cmd_t               cmd,
	output logic [EAW-1:0]              e_waddr,
	output logic [EAW-1:0]              e_raddr,
	output logic [TAW-1:0]              t_addr
);
	localparam int MN = MAX_N;
	localparam int CW = $clog2(MAX_N + 1);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_NEXT  = 5'd1;
	localparam logic [4:0] S_SCAN  = 5'd2;
	localparam logic [4:0] S_RD    = 5'd3;
	localparam logic [4:0] S_OPL   = 5'd4;
	localparam logic [4:0] S_MAG   = 5'd5;
	localparam logic [4:0] S_P1    = 5'd6;
	localparam logic [4:0] S_P2    = 5'd7;
	localparam logic [4:0] S_COMB  = 5'd8;
	localparam logic [4:0] S_ACC   = 5'd9;
	localparam logic [4:0] S_WT    = 5'd10;
	localparam logic [4:0] S_DBEG  = 5'd11;
	localparam logic [4:0] S_DET   = 5'd12;
	localparam logic [4:0] S_PREP  = 5'd13;
	localparam logic [4:0] S_DRD   = 5'd14;
	localparam logic [4:0] S_DOPL  = 5'd15;
	localparam logic [4:0] S_DINIT = 5'd16;
	localparam logic [4:0] S_DSTEP = 5'd17;
	localparam logic [4:0] S_DEND  = 5'd18;
	localparam logic [4:0] S_OUT   = 5'd19;

	localparam logic [1:0] PH_MIN = 2'd0;
	localparam logic [1:0] PH_DET = 2'd1;
	localparam logic [1:0] PH_DIV = 2'd2;

	logic [4:0]                state_q;
	logic [mia_pkg::CFG_W-1:0] size_q;
	logic [EAW-1:0]            load_q;
	logic [1:0]                phase_q;
	logic [CW-1:0]             k_q;
	logic [MN-1:0]             r_q;
	logic [MN-1:0]             cm_q;
	logic [CW-1:0]             c_q;
	logic                      j_q;
	logic [6:0]                step_q;
	logic [CW-1:0]             oi_q;
	logic [CW-1:0]             oj_q;

	logic [mia_pkg::CFG_W-1:0] n3;
	logic [CW-1:0]             n_c;
	logic [CW-1:0]             n_m1;
	logic [5:0]                cells_m1;
	logic [MN-1:0]             full;
	logic [CW-1:0]             r0;
	logic [MN-1:0]             sub_r;
	logic [MN-1:0]             sub_c;
	logic                      match;
	logic                      adv_done;
	logic [CW-1:0]             adv_k;
	logic [MN-1:0]             adv_r;
	logic [MN-1:0]             adv_c;
	logic                      col_set;
	logic                      out_last;

	function automatic logic [CW-1:0] pop(input logic [MN-1:0] m);
		logic [CW-1:0] cnt;
		cnt = '0;
		for (int b = 0; b < MN; b++) begin
			cnt = cnt + CW'(m[b]);
		end
		return cnt;
	endfunction

	function automatic logic [CW-1:0] lowest(input logic [MN-1:0] m);
		logic [CW-1:0] idx;
		idx = '0;
		for (int b = MN - 1; b >= 0; b--) begin
			if (m[b]) begin
				idx = CW'(b);
			end
		end
		return idx;
	endfunction

	function automatic logic [MN-1:0] bm(input logic [CW-1:0] x);
		return MN'(1) << x;
	endfunction

	always_comb begin
		// Size zero acts as order one; sizes above the maximum act as the maximum.
		if (size_q == '0) begin
			n3 = 3'd1;
		end else if (size_q > mia_pkg::CFG_W'(MAX_N)) begin
			n3 = mia_pkg::CFG_W'(MAX_N);
		end else begin
			n3 = size_q;
		end
		n_c      = CW'(n3);
		n_m1     = n_c - CW'(1);
		cells_m1 = 6'(n3) * 6'(n3) - 6'd1;
		for (int b = 0; b < MN; b++) begin
			full[b] = (b < int'(n3));
		end
		r0      = lowest(r_q);
		sub_r   = r_q & ~bm(r0);
		sub_c   = cm_q & ~bm(c_q);
		match   = (pop(r_q) == k_q) && (pop(cm_q) == k_q);
		col_set = cm_q[c_q[$clog2(MN > 1 ? MN : 2)-1:0]];
		out_last = (oi_q == n_m1) && (oj_q == n_m1);

		adv_done = 1'b0;
		adv_k = k_q;
		adv_r = r_q;
		adv_c = cm_q;
		if (cm_q != full) begin
			adv_c = cm_q + MN'(1);
		end else if (r_q != full) begin
			adv_r = r_q + MN'(1);
			adv_c = MN'(1);
		end else if (k_q != n_m1) begin
			adv_k = k_q + CW'(1);
			adv_r = MN'(1);
			adv_c = MN'(1);
		end else begin
			adv_done = 1'b1;
		end
	end

	always_comb begin
		cmd.op      = mia_pkg::OP_NONE;
		cmd.last    = out_last;
		cmd.termneg = (phase_q == PH_MIN) ? j_q : 1'b0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		// A size write is taken only while loading and never beside an element word.
		cfg_ready   = (state_q == S_LOAD) && !in_valid;
		e_waddr     = load_q;
		e_raddr     = EAW'(r0) * EAW'(n_c) + EAW'(c_q);
		if (phase_q == PH_DIV) begin
			t_addr      = {full & ~bm(oj_q), full & ~bm(oi_q)};
			cmd.src_one = ((full & ~bm(oj_q)) == '0);
			cmd.opneg   = oi_q[0] ^ oj_q[0];
		end else begin
			t_addr      = (state_q == S_WT) ? {r_q, cm_q} : {sub_r, sub_c};
			cmd.src_one = (sub_r == '0);
			cmd.opneg   = (phase_q == PH_DET) ? c_q[0] : 1'b0;
		end
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = mia_pkg::OP_LOAD;
				end
			end
			S_NEXT:  cmd.op = match ? mia_pkg::OP_CLR : mia_pkg::OP_NONE;
			S_OPL:   cmd.op = mia_pkg::OP_OPL;
			S_DOPL:  cmd.op = mia_pkg::OP_OPL;
			S_MAG:   cmd.op = mia_pkg::OP_MAG;
			S_P1:    cmd.op = mia_pkg::OP_P1;
			S_P2:    cmd.op = mia_pkg::OP_P2;
			S_COMB:  cmd.op = mia_pkg::OP_COMB;
			S_ACC:   cmd.op = mia_pkg::OP_ACC;
			S_WT:    cmd.op = mia_pkg::OP_WT;
			S_DBEG:  cmd.op = mia_pkg::OP_CLR;
			S_DET:   cmd.op = mia_pkg::OP_DET;
			S_PREP:  cmd.op = status.sing ? mia_pkg::OP_ZERO : mia_pkg::OP_NONE;
			S_DINIT: cmd.op = mia_pkg::OP_DINIT;
			S_DSTEP: cmd.op = mia_pkg::OP_DSTEP;
			S_DEND:  cmd.op = mia_pkg::OP_DEND;
			S_OUT:   out_valid = 1'b1;
			default: cmd.op = mia_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			size_q  <= mia_pkg::SIZE_RESET;
			load_q  <= '0;
			phase_q <= PH_MIN;
			k_q     <= '0;
			r_q     <= '0;
			cm_q    <= '0;
			c_q     <= '0;
			j_q     <= 1'b0;
			step_q  <= '0;
			oi_q    <= '0;
			oj_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
				load_q <= '0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (6'(load_q) == cells_m1) begin
							load_q <= '0;
							if (n3 == 3'd1) begin
								state_q <= S_DBEG;
							end else begin
								phase_q <= PH_MIN;
								k_q     <= CW'(1);
								r_q     <= MN'(1);
								cm_q    <= MN'(1);
								state_q <= S_NEXT;
							end
						end else begin
							load_q <= load_q + EAW'(1);
						end
					end
				end
				S_NEXT: begin
					if (match) begin
						c_q     <= '0;
						j_q     <= 1'b0;
						state_q <= S_SCAN;
					end else if (adv_done) begin
						state_q <= S_DBEG;
					end else begin
						k_q  <= adv_k;
						r_q  <= adv_r;
						cm_q <= adv_c;
					end
				end
				S_SCAN: begin
					if (col_set) begin
						state_q <= S_RD;
					end else if (c_q == n_m1) begin
						state_q <= (phase_q == PH_MIN) ? S_WT : S_DET;
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				S_RD:   state_q <= S_OPL;
				S_OPL:  state_q <= S_MAG;
				S_MAG:  state_q <= S_P1;
				S_P1:   state_q <= S_P2;
				S_P2:   state_q <= S_COMB;
				S_COMB: state_q <= S_ACC;
				S_ACC: begin
					j_q <= ~j_q;
					if (c_q == n_m1) begin
						state_q <= (phase_q == PH_MIN) ? S_WT : S_DET;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_SCAN;
					end
				end
				S_WT: begin
					if (adv_done) begin
						state_q <= S_DBEG;
					end else begin
						k_q     <= adv_k;
						r_q     <= adv_r;
						cm_q    <= adv_c;
						state_q <= S_NEXT;
					end
				end
				S_DBEG: begin
					// The determinant is the first-row expansion against the cofactors.
					phase_q <= PH_DET;
					r_q     <= full;
					cm_q    <= full;
					c_q     <= '0;
					state_q <= S_SCAN;
				end
				S_DET: begin
					phase_q <= PH_DIV;
					oi_q    <= '0;
					oj_q    <= '0;
					state_q <= S_PREP;
				end
				S_PREP:  state_q <= status.sing ? S_OUT : S_DRD;
				S_DRD:   state_q <= S_DOPL;
				S_DOPL:  state_q <= S_DINIT;
				S_DINIT: begin
					step_q  <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					step_q <= step_q + 7'd1;
					if (step_q == 7'(mia_pkg::DIV_STEPS - 1)) begin
						state_q <= S_DEND;
					end
				end
				S_DEND: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						if (out_last) begin
							phase_q <= PH_MIN;
							state_q <= S_LOAD;
						end else begin
							if (oj_q == n_m1) begin
								oj_q <= '0;
								oi_q <= oi_q + CW'(1);
							end else begin
								oj_q <= oj_q + CW'(1);
							end
							state_q <= S_PREP;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

/* hw/rtl/mia_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the matrix inverter, attached to the top level by bind.
// Depends on mia_pkg and matrix_inverse_adjugate_core.
module mia_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [mia_pkg::ELEM_W-1:0] inverse_element,
	input logic signed [mia_pkg::DET_W-1:0]  determinant,
	input logic                              singular,
	input logic                              last
);
	// Loading and result delivery never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is offered");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result word dropped while stalled");

	// The determinant belongs to the whole burst.
	a_det_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> $stable(determinant))
		else $error("determinant changed within a burst");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && singular) |-> (inverse_element == '0))
		else $error("singular result with a nonzero element");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> (!out_valid && in_ready))
		else $error("burst did not end after the last word");
endmodule

bind matrix_inverse_adjugate_core mia_checker u_mia_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (matrix.ready),
	.out_valid      (inverse.valid),
	.out_ready      (inverse.ready),
	.inverse_element(inverse.inverse_element),
	.determinant    (inverse.determinant),
	.singular       (inverse.singular),
	.last           (inverse.last)
);
